// ===== hdl/btm_pkg.sv =====
// Shared types and constants for the button teach menu controller.
// Used by btm_cfg, btm_core and button_teach_menu_fsm; depends on nothing else.
package btm_pkg;

  // Widths fixed by the item and register formats.
  localparam int unsigned THR_W       = 24;
  localparam int unsigned IDX_W       = 8;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned IN_DATA_W   = 8;
  localparam int unsigned OUT_DATA_W  = 32;

  // Defaults for the top-level parameters.
  localparam int unsigned NUM_SIGNATURES_DEF = 7;
  localparam int unsigned TIMER_BITS_DEF     = 24;

  // Highest LED color index that can be blinked.
  localparam logic [IDX_W-1:0] LED_COLOR_LAST = 8'd7;

  // Flash counts that go with the flash actions.
  localparam logic [2:0] FLASH_SHOW_COUNT = 3'd3;
  localparam logic [2:0] FLASH_OFF_COUNT  = 3'd4;
  localparam logic [2:0] FLASH_NONE       = 3'd0;

  // Register reset values.
  localparam logic [THR_W-1:0] HOLD_TICKS_RST   = 24'd1000;
  localparam logic [THR_W-1:0] CYCLE_TICKS_RST  = 24'd1000;
  localparam logic [THR_W-1:0] ABORT_TICKS_RST  = 24'd30000;
  localparam logic [THR_W-1:0] PROG_WAIT_RST    = 24'd3000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MENU_MODE       = 3'd0,
    REG_PROGRAM_COUNT   = 3'd1,
    REG_DEFAULT_PROGRAM = 3'd2,
    REG_HOLD_TICKS      = 3'd3,
    REG_CYCLE_TICKS     = 3'd4,
    REG_ABORT_TICKS     = 3'd5,
    REG_PROG_WAIT_TICKS = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    FRAME_NONE  = 2'd0,
    FRAME_KEEP  = 2'd1,
    FRAME_FLUSH = 2'd2
  } frame_req_e;

  typedef enum logic [2:0] {
    LED_NONE       = 3'd0,
    LED_OFF        = 3'd1,
    LED_BLINK_SHOW = 3'd2,
    LED_FLASH_SHOW = 3'd3,
    LED_FLASH_OFF  = 3'd4
  } led_act_e;

  typedef enum logic [1:0] {
    AWB_NONE    = 2'd0,
    AWB_ENABLE  = 2'd1,
    AWB_DISABLE = 2'd2
  } awb_cmd_e;

  // Configuration register contents.
  typedef struct packed {
    logic             menu_mode;
    logic [IDX_W-1:0] program_count;
    logic [IDX_W-1:0] default_program;
    logic [THR_W-1:0] hold_ticks;
    logic [THR_W-1:0] cycle_ticks;
    logic [THR_W-1:0] abort_ticks;
    logic [THR_W-1:0] program_wait_ticks;
  } cfg_t;

  // One result item, first field in the highest bits.
  typedef struct packed {
    logic [IDX_W-1:0] selected_program;
    logic             selection_chosen;
    logic             selection_done;
    logic             save_signature;
    awb_cmd_e         awb_command;
    logic             restore_brightness;
    logic [IDX_W-1:0] led_index;
    logic [2:0]       flash_count;
    led_act_e         led_action;
    logic             light_pipe_active;
    frame_req_e       frame_request;
    logic             busy_res;
  } res_t;

endpackage

// ===== hdl/button_teach_menu_fsm.sv =====
// Single-button menu controller: input stage, handshake control and the
// instances of btm_cfg and btm_core. Depends on btm_pkg.
//
// Usage: each transfer on the slave stream is one tick carrying the button
// level and the white-balance status; each tick yields exactly one result
// transfer on the master stream with the LED, brightness, white-balance,
// signature-save, frame-grab and program-selection commands.
// Path: the tick is held in the input register and then processed into
// the result register, which offers it on the master stream.
// Throughput: one tick per cycle while m_axis_tready stays high, as the
// phase update between the input register and the result register is
// combinational.
// Stalls: while the receiver holds m_axis_tready low, one tick more is taken
// into the input register and s_axis_tready then falls until the result
// register is emptied. No tick is dropped or processed twice.
// Configuration: registers are written through cfg_we_i, cfg_idx_i and
// cfg_data_i with no wait; write them only while no tick is in flight.
// Reset: rst_ni clears the phase to idle, the index, tick counter and
// light-pipe flag to zero, empties both stages and loads the register
// defaults.
module button_teach_menu_fsm
  import btm_pkg::*;
#(
  parameter int unsigned NUM_SIGNATURES = NUM_SIGNATURES_DEF,
  parameter int unsigned TIMER_BITS     = TIMER_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Tick stream.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // button_down, awb_enabled, zero pad
  // Result stream.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // busy_res, frame_request, light_pipe_active, led_action, flash_count,
  // led_index, restore_brightness, awb_command, save_signature,
  // selection_done, selection_chosen, selected_program
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // Configuration write port.
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [THR_W-1:0]      cfg_data_i
);

  logic in_valid_q, in_valid_d;
  logic in_bt_q, in_awb_q;
  logic out_valid_q, out_valid_d;
  logic advance;
  logic load;
  logic s_xfer;
  cfg_t cfg;
  res_t res;

  // The result register may load when it is empty or being drained.
  assign advance       = !out_valid_q || m_axis_tready;
  assign load          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  // Stage occupancy.
  always_comb begin
    in_valid_d = in_valid_q;
    if (s_xfer) begin
      in_valid_d = 1'b1;
    end else if (load) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input payload register.
  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      in_bt_q  <= s_axis_tdata[0];
      in_awb_q <= s_axis_tdata[1];
    end
  end

  btm_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  btm_core #(
    .NUM_SIGNATURES (NUM_SIGNATURES),
    .TIMER_BITS     (TIMER_BITS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .button_down_i (in_bt_q),
    .awb_enabled_i (in_awb_q),
    .cfg_i         (cfg),
    .res_o         (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = res;

endmodule

// ===== hdl/btm_cfg.sv =====
// Configuration register file of the button teach menu controller.
// Depends on btm_pkg for the register index codes and the cfg_t struct.
module btm_cfg
  import btm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [THR_W-1:0]     cfg_data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode the register index; indexes beyond the list are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_MENU_MODE:       cfg_d.menu_mode          = cfg_data_i[0];
        REG_PROGRAM_COUNT:   cfg_d.program_count      = cfg_data_i[IDX_W-1:0];
        REG_DEFAULT_PROGRAM: cfg_d.default_program    = cfg_data_i[IDX_W-1:0];
        REG_HOLD_TICKS:      cfg_d.hold_ticks         = cfg_data_i;
        REG_CYCLE_TICKS:     cfg_d.cycle_ticks        = cfg_data_i;
        REG_ABORT_TICKS:     cfg_d.abort_ticks        = cfg_data_i;
        REG_PROG_WAIT_TICKS: cfg_d.program_wait_ticks = cfg_data_i;
        default:             cfg_d                    = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.menu_mode          <= 1'b0;
      cfg_q.program_count      <= '0;
      cfg_q.default_program    <= '0;
      cfg_q.hold_ticks         <= HOLD_TICKS_RST;
      cfg_q.cycle_ticks        <= CYCLE_TICKS_RST;
      cfg_q.abort_ticks        <= ABORT_TICKS_RST;
      cfg_q.program_wait_ticks <= PROG_WAIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/btm_core.sv =====
// Menu phase machine, saturating tick counter and result register.
// Depends on btm_pkg for the config and result types and the action codes.
module btm_core
  import btm_pkg::*;
#(
  parameter int unsigned NUM_SIGNATURES = NUM_SIGNATURES_DEF,
  parameter int unsigned TIMER_BITS     = TIMER_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  logic button_down_i,
  input  logic awb_enabled_i,
  input  cfg_t cfg_i,
  output res_t res_o
);

  localparam int unsigned CMP_W = (TIMER_BITS > THR_W) ? TIMER_BITS : THR_W;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
  localparam logic [IDX_W-1:0] SIG_WRAP = IDX_W'(NUM_SIGNATURES + 1);

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_PRESS   = 3'd1,
    PH_CYCLE   = 3'd2,
    PH_WAIT    = 3'd3,
    PH_CONFIRM = 3'd4,
    PH_RELEASE = 3'd5
  } phase_e;

  phase_e                ph_q, ph_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [TIMER_BITS-1:0] el_q, el_d;
  logic                  lp_q, lp_d;
  res_t                  res_q, res_d;

  logic [TIMER_BITS-1:0] el_inc;
  logic [IDX_W-1:0]      idx_next;
  logic [IDX_W-1:0]      idx_blink;
  logic                  do_blink;
  logic                  do_clear;
  logic                  hold_over, cycle_over, abort_over, pwait_over;
  logic                  few_programs;

  // Saturating tick count and the timeout compares.
  assign el_inc     = (el_q == TIMER_MAX) ? el_q : el_q + 1'b1;
  assign hold_over  = CMP_W'(el_inc) > CMP_W'(cfg_i.hold_ticks);
  assign cycle_over = CMP_W'(el_inc) > CMP_W'(cfg_i.cycle_ticks);
  assign abort_over = CMP_W'(el_inc) > CMP_W'(cfg_i.abort_ticks);
  assign pwait_over = CMP_W'(el_inc) > CMP_W'(cfg_i.program_wait_ticks);

  assign few_programs = (cfg_i.program_count <= 8'd1);

  // Next phase, index, counter and result for one tick.
  always_comb begin
    ph_d      = ph_q;
    idx_d     = idx_q;
    el_d      = el_inc;
    lp_d      = lp_q;
    res_d     = '0;
    do_blink  = 1'b0;
    do_clear  = 1'b0;
    idx_blink = idx_q;
    idx_next  = idx_q + 1'b1;

    if (!cfg_i.menu_mode) begin
      // Teach menu: frame grab depends on the state at the start of the tick.
      if (lp_q) begin
        res_d.frame_request     = FRAME_KEEP;
        res_d.light_pipe_active = 1'b1;
      end else if (ph_q != PH_IDLE) begin
        res_d.frame_request = FRAME_FLUSH;
      end

      if (idx_next == SIG_WRAP) begin
        idx_next = '0;
      end

      unique case (ph_q)
        PH_IDLE: begin
          if (button_down_i) begin
            el_d                     = '0;
            res_d.restore_brightness = 1'b1;
            res_d.led_action         = LED_OFF;
            ph_d                     = PH_PRESS;
          end
        end
        PH_PRESS: begin
          if (!button_down_i) begin
            ph_d = PH_IDLE;
          end else if (hold_over) begin
            idx_d     = {{(IDX_W-1){1'b0}}, awb_enabled_i};
            idx_blink = {{(IDX_W-1){1'b0}}, awb_enabled_i};
            el_d      = '0;
            do_blink  = 1'b1;
            ph_d      = PH_CYCLE;
          end
        end
        PH_CYCLE: begin
          if (!button_down_i) begin
            res_d.led_action  = LED_FLASH_SHOW;
            res_d.flash_count = FLASH_SHOW_COUNT;
            res_d.led_index   = idx_q;
            el_d              = '0;
            if (idx_q == '0) begin
              res_d.awb_command = AWB_ENABLE;
            end else begin
              lp_d = 1'b1;
            end
            ph_d = PH_WAIT;
          end else if (cycle_over) begin
            el_d      = '0;
            idx_d     = idx_next;
            idx_blink = idx_next;
            do_blink  = 1'b1;
          end
        end
        PH_WAIT: begin
          if (button_down_i) begin
            el_d = '0;
            ph_d = PH_CONFIRM;
          end else if (abort_over) begin
            do_clear = 1'b1;
          end
        end
        PH_CONFIRM: begin
          if (!button_down_i) begin
            if (idx_q == '0) begin
              res_d.awb_command = AWB_DISABLE;
            end else begin
              res_d.save_signature = 1'b1;
            end
            do_clear = 1'b1;
          end else if (hold_over) begin
            if (idx_q == '0) begin
              res_d.awb_command = AWB_DISABLE;
            end
            do_clear = 1'b1;
          end
        end
        PH_RELEASE: begin
          if (!button_down_i) begin
            do_clear = 1'b1;
          end
        end
        default: begin
          do_clear = 1'b1;
        end
      endcase
    end else if (few_programs) begin
      // Nothing to choose: the default is selected and the phase and index hold.
      res_d.selection_done   = 1'b1;
      res_d.selected_program = cfg_i.default_program;
    end else begin
      // Program selection menu.
      if (idx_next == cfg_i.program_count) begin
        idx_next = '0;
      end

      unique case (ph_q)
        PH_IDLE: begin
          el_d     = '0;
          ph_d     = PH_PRESS;
          do_blink = 1'b1;
        end
        PH_PRESS: begin
          if (button_down_i) begin
            el_d      = '0;
            idx_d     = '0;
            idx_blink = '0;
            do_blink  = 1'b1;
            ph_d      = PH_CYCLE;
          end else if (pwait_over) begin
            do_clear = 1'b1;
          end
        end
        PH_CYCLE: begin
          if (!button_down_i) begin
            do_clear               = 1'b1;
            res_d.selection_done   = 1'b1;
            res_d.selection_chosen = 1'b1;
            res_d.selected_program = idx_q;
          end else if (cycle_over) begin
            el_d      = '0;
            idx_d     = idx_next;
            idx_blink = idx_next;
            do_blink  = 1'b1;
          end
        end
        default: begin
          do_clear = 1'b1;
        end
      endcase
    end

    // Blink the shown index when it is a displayable color.
    if (do_blink && (idx_blink <= LED_COLOR_LAST)) begin
      res_d.led_action = LED_BLINK_SHOW;
      res_d.led_index  = idx_blink;
    end

    // Leaving the menu turns the LED off unless a final flash is due.
    if (do_clear) begin
      idx_d             = '0;
      lp_d              = 1'b0;
      ph_d              = PH_IDLE;
      res_d.led_action  = LED_OFF;
      res_d.flash_count = FLASH_NONE;
      res_d.led_index   = '0;
      if (!cfg_i.menu_mode && ph_q == PH_CONFIRM && !button_down_i) begin
        res_d.led_action  = LED_FLASH_OFF;
        res_d.flash_count = FLASH_OFF_COUNT;
        res_d.led_index   = idx_q;
      end else if (!cfg_i.menu_mode && ph_q == PH_CONFIRM) begin
        // A long hold on confirm cancels, then waits for the release.
        ph_d = PH_RELEASE;
      end else if (cfg_i.menu_mode && ph_q == PH_PRESS) begin
        res_d.led_action       = LED_FLASH_OFF;
        res_d.flash_count      = FLASH_OFF_COUNT;
        res_d.led_index        = cfg_i.default_program;
        res_d.selection_done   = 1'b1;
        res_d.selected_program = cfg_i.default_program;
      end else if (cfg_i.menu_mode && ph_q == PH_CYCLE) begin
        res_d.led_action  = LED_FLASH_OFF;
        res_d.flash_count = FLASH_OFF_COUNT;
        res_d.led_index   = idx_q;
      end
    end

    res_d.busy_res = (ph_d != PH_IDLE);
  end

  // Menu state and result register, updated once per processed tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= PH_IDLE;
      idx_q <= '0;
      el_q  <= '0;
      lp_q  <= 1'b0;
      res_q <= '0;
    end else if (load_i) begin
      ph_q  <= ph_d;
      idx_q <= idx_d;
      el_q  <= el_d;
      lp_q  <= lp_d;
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule
